// ----- rtl/nbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// nbpm_pkg
// Shared types, constants and helpers for the byte pattern matcher.
// ----------------------------------------------------------------------------
package nbpm_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int POSITION_BITS     = 24;
   localparam int START_BITS        = 24;
   localparam int WINDOW_DEPTH      = MAX_PATTERN_BYTES - 1;
   localparam int LEN_BITS          = 5;
   localparam int IDX_BITS          = $clog2(MAX_PATTERN_BYTES);
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 64;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd2;

   // Window control handed to every cell.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // Picks pattern byte idx out of the two 64-bit pattern registers.
   function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
                                               input logic [63:0] hi,
                                               input logic [IDX_BITS-1:0] idx);
      logic [127:0] all_bytes;
      all_bytes = {hi, lo};
      return all_bytes[{idx, 3'b000} +: 8];
   endfunction

endpackage

// ----- rtl/nbpm_cell.sv -----
// ----------------------------------------------------------------------------
// nbpm_cell
// One window cell: holds one past text byte, passes it to its neighbor on
// every shift and compares it against the pattern byte it is aligned with.
// ----------------------------------------------------------------------------
module nbpm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  nbpm_pkg::cell_ctl_type ctl,
   input  logic [7:0]            byte_in,
   input  logic [7:0]            pat_byte,
   input  logic                  in_use,
   output logic [7:0]            byte_out,
   output logic                  match
);
   import nbpm_pkg::*;

   logic [7:0] held_ff;
   logic [7:0] held_in;

   always_comb begin
      held_in = held_ff;
      if (ctl.clear) begin
         held_in = 8'd0;
      end else if (ctl.shift) begin
         held_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 8'd0;
      end else begin
         held_ff <= held_in;
      end
   end

   // A cell beyond the active pattern never blocks a match.
   assign match    = !in_use || (held_ff == pat_byte);
   assign byte_out = held_ff;

endmodule

// ----- rtl/nonoverlapping_byte_pattern_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// nonoverlapping_byte_pattern_matcher_unit
// Streams a text one byte per request and flags the leftmost
// non-overlapping occurrences of a configured 1 to 16 byte pattern.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  req_*     in         req_valid/req_stall  text_byte, end_of_text
//  rsp_*     out        rsp_valid/rsp_stall  match_found, match_start, last_result
//  csr_*     in         csr_write_enable     csr_index, csr_write_data
//
// Every request yields exactly one response, in the cycle after it is taken.
// The block takes one request per cycle while req_stall is low; the compare
// across the chain of window cells is combinational into the response register.
// Reset is synchronous and clears the window, position, block count, the
// pattern registers (length to one) and the response valid.
// While a response waits under rsp_stall, req_stall is raised in the same
// cycle, so the pipeline holds without losing or repeating a request.
//
module nonoverlapping_byte_pattern_matcher_unit
   import nbpm_pkg::CSR_INDEX_BITS;
   import nbpm_pkg::CSR_DATA_BITS;
   import nbpm_pkg::START_BITS;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_text_byte,
   input  logic                      req_end_of_text,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_match_found,
   output logic [START_BITS-1:0]     rsp_match_start,
   output logic                      rsp_last_result,
   // configuration port
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);
   import nbpm_pkg::*;

   // Configuration registers.
   logic [63:0]         pat_lo_ff;
   logic [63:0]         pat_hi_ff;
   logic [LEN_BITS-1:0] pat_len_ff;

   // Search state outside the window.
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] pos_in;
   logic [IDX_BITS-1:0]      blk_ff;
   logic [IDX_BITS-1:0]      blk_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_found_ff;
   logic [START_BITS-1:0] rsp_start_ff;
   logic                  rsp_last_ff;

   logic                     req_accept;
   logic [IDX_BITS-1:0]      len_m1;
   logic                     cur_match;
   logic                     pos_ok;
   logic                     hit;
   logic [POSITION_BITS-1:0] start;
   cell_ctl_type             cell_ctl;

   logic [7:0]              win_byte [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] cell_match;

   // The response register empties or is taken in the same cycle.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Active length minus one: a length of zero acts as one, anything
   // above the maximum acts as the maximum.
   always_comb begin
      if (pat_len_ff == '0) begin
         len_m1 = '0;
      end else if (pat_len_ff > LEN_BITS'(MAX_PATTERN_BYTES)) begin
         len_m1 = IDX_BITS'(MAX_PATTERN_BYTES - 1);
      end else begin
         len_m1 = IDX_BITS'(pat_len_ff - LEN_BITS'(1));
      end
   end

   // The newest byte lines up with the last pattern byte.
   assign cur_match = (req_text_byte == pattern_byte(pat_lo_ff, pat_hi_ff, len_m1));

   assign cell_ctl.shift = req_accept && !req_end_of_text;
   assign cell_ctl.clear = req_accept && req_end_of_text;

   // Window cell k holds the byte k+1 places back and lines up with
   // pattern byte len-2-k while k is below len-1.
   for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
      logic                in_use;
      logic [IDX_BITS-1:0] pat_idx;
      logic [7:0]          byte_in;

      assign in_use  = IDX_BITS'(k) < len_m1;
      assign pat_idx = len_m1 - IDX_BITS'(k + 1);

      if (k == 0) begin : g_head
         assign byte_in = req_text_byte;
      end else begin : g_link
         assign byte_in = win_byte[k-1];
      end

      nbpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .byte_in  (byte_in),
         .pat_byte (pattern_byte(pat_lo_ff, pat_hi_ff, pat_idx)),
         .in_use   (in_use),
         .byte_out (win_byte[k]),
         .match    (cell_match[k])
      );
   end

   // A match needs enough bytes since the start of text and no pending
   // block left over from the previous match.
   assign pos_ok = pos_ff >= POSITION_BITS'(len_m1);
   assign hit    = (blk_ff == '0) && pos_ok && cur_match && (&cell_match);
   assign start  = (pos_ff == POS_MAX) ? POS_MAX : pos_ff - POSITION_BITS'(len_m1);

   always_comb begin
      pos_in = pos_ff;
      blk_in = blk_ff;
      if (req_accept) begin
         if (req_end_of_text) begin
            pos_in = '0;
            blk_in = '0;
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POSITION_BITS'(1);
            end
            if (blk_ff != '0) begin
               blk_in = blk_ff - IDX_BITS'(1);
            end else if (hit) begin
               blk_in = len_m1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         pat_len_ff   <= LEN_BITS'(1);
         pos_ff       <= '0;
         blk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_PATTERN_LOW:    pat_lo_ff  <= csr_write_data;
               REG_PATTERN_HIGH:   pat_hi_ff  <= csr_write_data;
               REG_PATTERN_LENGTH: pat_len_ff <= csr_write_data[LEN_BITS-1:0];
               default:            ;
            endcase
         end
         pos_ff       <= pos_in;
         blk_ff       <= blk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset; it is loaded with every request.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_found_ff <= hit;
         rsp_start_ff <= hit ? START_BITS'(start) : '0;
         rsp_last_ff  <= req_end_of_text;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_match_start = rsp_start_ff;
   assign rsp_last_result = rsp_last_ff;

   // A pending block count always suppresses the match for that byte.
   a_block_suppresses: assert property (@(posedge clock) disable iff (reset)
      req_accept && (blk_ff != '0) |=> !rsp_match_found)
      else $error("match reported while overlap block was pending");

   // End of text returns the search to its starting state.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_text |=> (pos_ff == '0) && (blk_ff == '0))
      else $error("search state not cleared after end of text");

   // A match arms the block count with the active length minus one.
   a_hit_arms_block: assert property (@(posedge clock) disable iff (reset)
      req_accept && hit && !req_end_of_text && !csr_write_enable
      |=> blk_ff == $past(len_m1))
      else $error("block count not armed after match");

   // A response without a match carries a zero start position.
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_match_found |-> rsp_match_start == '0)
      else $error("nonzero start on a response without a match");

endmodule
